@@ hw/rtl/cdq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the circular deque: widths, command codes, register map.
package cdq_pkg;

	localparam int CDQ_DEPTH = 1024;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int CAP_W     = 11;
	localparam int APB_DW    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// Register indexes, taken from paddr above the byte offset
	localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NOP        = 3'd4;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

@@ hw/rtl/cdq_if.sv @@
`timescale 1ns / 1ps
// Command and result channel interfaces of the circular deque.
interface cdq_req_if;
	logic                              valid;
	logic                              ready;
	logic [cdq_pkg::CMD_W-1:0]         command;
	logic signed [cdq_pkg::DATA_W-1:0] data_value;

	modport source (output valid, output command, output data_value, input ready);
	modport sink (input valid, input command, input data_value, output ready);
endinterface

interface cdq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              accepted;
	logic signed [cdq_pkg::DATA_W-1:0] front_value;
	logic signed [cdq_pkg::DATA_W-1:0] rear_value;
	logic                              is_empty;
	logic                              is_full;

	modport source (output valid, output accepted, output front_value, output rear_value,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input accepted, input front_value, input rear_value,
		input is_empty, input is_full, output ready);
endinterface

@@ hw/rtl/circular_deque.sv @@
`timescale 1ns / 1ps
// Circular deque of signed 32-bit words in a ring memory, with APB capacity register.
//
// One command word is taken every cycle unless the result stages are stalled by rsp.ready,
// and each gives one result word: a stage that registers the ring memory reads at the new
// front and back pointers, then the output register. The ring memory, with one write port and
// two read ports, fixes that rate; the read sees the memory before a push's own write,
// so that word is forwarded to its own result. The ring memory needs no clearing after
// reset: only pushed entries are ever shown. Writing the capacity register (byte
// address 0) empties the deque; a capacity of 0 acts as 1 and one above DEPTH acts as
// DEPTH.
module circular_deque #(
	parameter int DEPTH = cdq_pkg::CDQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cdq_req_if.sink                     req,
	cdq_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]  paddr,
	input  logic [cdq_pkg::APB_DW-1:0]  pwdata,
	output logic [cdq_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import cdq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [DATA_W-1:0] word_t;

	logic [CAP_W-1:0] capacity_q;
	ptr_t             front_ptr_q;
	ptr_t             back_ptr_q;
	cnt_t             occ_q;

	word_t ring_mem [DEPTH];

	logic  cfg_wr;
	logic  in_fire;
	logic  move_s1;
	cnt_t  cap_eff;
	logic  is_full_now;
	logic  is_empty_now;
	ptr_t  nxt_front;
	ptr_t  nxt_back;
	cnt_t  nxt_occ;
	logic  acc;
	logic  wr_en;
	ptr_t  wr_addr;

	logic  valid_s1;
	logic  acc_s1;
	logic  empty_s1;
	logic  full_s1;
	logic  byp_front_s1;
	logic  byp_back_s1;
	word_t wdata_s1;
	word_t rd_front_s1;
	word_t rd_back_s1;

	logic  out_valid_q;
	logic  accepted_q;
	word_t front_value_q;
	word_t rear_value_q;
	logic  is_empty_q;
	logic  is_full_q;

	function automatic ptr_t ptr_inc(ptr_t p, cnt_t cap);
		cnt_t p1;
		p1 = cnt_t'(p) + cnt_t'(1);
		return (p1 >= cap) ? '0 : PTR_W'(p1);
	endfunction

	function automatic ptr_t ptr_dec(ptr_t p, cnt_t cap);
		return (p == '0 || cnt_t'(p) >= cap) ? PTR_W'(cap - cnt_t'(1)) : p - ptr_t'(1);
	endfunction

	// APB side: single register, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CAPACITY);
	assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;

	// Saturate capacity into 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = cnt_t'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
			cap_eff = cnt_t'(DEPTH);
		end else begin
			cap_eff = cnt_t'(capacity_q);
		end
	end

	assign is_full_now  = (occ_q >= cap_eff);
	assign is_empty_now = (occ_q == '0);

	assign move_s1   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || move_s1;
	assign in_fire   = req.valid && req.ready;

	always_comb begin
		nxt_front = front_ptr_q;
		nxt_back  = back_ptr_q;
		nxt_occ   = occ_q;
		acc       = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = front_ptr_q;
		unique case (req.command)
			CMD_PUSH_FRONT: begin
				if (!is_full_now) begin
					nxt_front = ptr_dec(front_ptr_q, cap_eff);
					wr_en     = 1'b1;
					wr_addr   = nxt_front;
					nxt_occ   = occ_q + cnt_t'(1);
					if (is_empty_now) begin
						nxt_back = nxt_front;
					end
					acc = 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (!is_full_now) begin
					nxt_back = ptr_inc(back_ptr_q, cap_eff);
					wr_en    = 1'b1;
					wr_addr  = nxt_back;
					nxt_occ  = occ_q + cnt_t'(1);
					if (is_empty_now) begin
						nxt_front = nxt_back;
					end
					acc = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (!is_empty_now) begin
					nxt_front = ptr_inc(front_ptr_q, cap_eff);
					nxt_occ   = occ_q - cnt_t'(1);
					if (occ_q == cnt_t'(1)) begin
						nxt_back = nxt_front;
					end
					acc = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (!is_empty_now) begin
					nxt_back = ptr_dec(back_ptr_q, cap_eff);
					nxt_occ  = occ_q - cnt_t'(1);
					if (occ_q == cnt_t'(1)) begin
						nxt_front = nxt_back;
					end
					acc = 1'b1;
				end
			end
			CMD_NOP: begin
				acc = 1'b1;
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			front_ptr_q <= '0;
			back_ptr_q  <= '0;
			occ_q       <= '0;
		end else if (cfg_wr) begin
			// new capacity: drop all contents
			capacity_q  <= pwdata[CAP_W-1:0];
			front_ptr_q <= '0;
			back_ptr_q  <= '0;
			occ_q       <= '0;
		end else if (in_fire) begin
			front_ptr_q <= nxt_front;
			back_ptr_q  <= nxt_back;
			occ_q       <= nxt_occ;
		end
	end

	// Ring memory: one write, two registered reads at the new pointers
	always_ff @(posedge clk) begin
		if (in_fire && wr_en) begin
			ring_mem[wr_addr] <= req.data_value;
		end
		if (in_fire) begin
			rd_front_s1 <= ring_mem[nxt_front];
			rd_back_s1  <= ring_mem[nxt_back];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_s1       <= acc;
			empty_s1     <= (nxt_occ == '0);
			full_s1      <= (nxt_occ >= cap_eff);
			// forward this word's write past the old memory read
			byp_front_s1 <= wr_en && (wr_addr == nxt_front);
			byp_back_s1  <= wr_en && (wr_addr == nxt_back);
			wdata_s1     <= req.data_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			accepted_q    <= acc_s1;
			is_empty_q    <= empty_s1;
			is_full_q     <= full_s1;
			front_value_q <= empty_s1 ? EMPTY_VALUE : (byp_front_s1 ? wdata_s1 : rd_front_s1);
			rear_value_q  <= empty_s1 ? EMPTY_VALUE : (byp_back_s1 ? wdata_s1 : rd_back_s1);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.accepted    = accepted_q;
	assign rsp.front_value = front_value_q;
	assign rsp.rear_value  = rear_value_q;
	assign rsp.is_empty    = is_empty_q;
	assign rsp.is_full     = is_full_q;

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_eff)
		else $error("occupancy above capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> front_ptr_q == back_ptr_q)
		else $error("empty deque with split pointers");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_full_now && (req.command == CMD_PUSH_FRONT ||
		req.command == CMD_PUSH_BACK) |=> !acc_s1 && full_s1)
		else $error("push taken while full");

	a_empty_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_empty_now && (req.command == CMD_POP_FRONT ||
		req.command == CMD_POP_BACK) |=> !acc_s1 && empty_s1)
		else $error("pop taken while empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move_s1 |=> valid_s1 && $stable(acc_s1) && $stable(empty_s1))
		else $error("result stage lost a word under stall");
`endif

endmodule

@@ tb/tb_circular_deque.sv @@
`timescale 1ns / 1ps
// Testbench for circular_deque: directed and random command streams checked against a deque model.
module tb_circular_deque;
	import cdq_pkg::*;

	localparam int                CYCLE_LIMIT   = 200000;
	localparam int                SETTLE_CYCLES = 6;
	localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
	localparam int                CMD_LAST      = (1 << CMD_W) - 1;

	typedef struct packed {
		logic              accepted;
		logic [DATA_W-1:0] front_value;
		logic [DATA_W-1:0] rear_value;
		logic              is_empty;
		logic              is_full;
	} deque_status_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	cdq_req_if req_ch();
	cdq_rsp_if rsp_ch();

	circular_deque DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// deque model state
	logic [DATA_W-1:0] slot_mem [CDQ_DEPTH];
	logic [9:0]        head_slot;
	logic [9:0]        tail_slot;
	logic [CAP_W-1:0]  fill_count;
	logic [CAP_W-1:0]  cap_reg;

	deque_status_t awaited_status[$];
	int            error_count;
	int            cycle_count;
	bit            send_gaps_on;
	bit            recv_stalls_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [CAP_W-1:0] cap_in_use();
		if (cap_reg == '0)
			return 11'd1;
		if (cap_reg > CDQ_DEPTH)
			return CAP_W'(CDQ_DEPTH);
		return cap_reg;
	endfunction

	function automatic logic [9:0] slot_after(input logic [9:0] p, input logic [CAP_W-1:0] lim);
		logic [CAP_W-1:0] wide;
		wide = {1'b0, p} + 11'd1;
		return (wide >= lim) ? 10'd0 : wide[9:0];
	endfunction

	function automatic logic [9:0] slot_before(input logic [9:0] p, input logic [CAP_W-1:0] lim);
		logic [CAP_W-1:0] top;
		top = lim - 11'd1;
		return (p == 10'd0 || {1'b0, p} >= lim) ? top[9:0] : p - 10'd1;
	endfunction

	function automatic deque_status_t apply_command(input logic [CMD_W-1:0] cmd,
		input logic [DATA_W-1:0] val);
		deque_status_t st;
		logic [CAP_W-1:0] lim;
		logic ok;
		lim = cap_in_use();
		ok = 1'b0;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (fill_count < lim) begin
					head_slot = slot_before(head_slot, lim);
					slot_mem[head_slot] = val;
					fill_count++;
					if (fill_count == 11'd1)
						tail_slot = head_slot;
					ok = 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (fill_count < lim) begin
					tail_slot = slot_after(tail_slot, lim);
					slot_mem[tail_slot] = val;
					fill_count++;
					if (fill_count == 11'd1)
						head_slot = tail_slot;
					ok = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (fill_count != '0) begin
					head_slot = slot_after(head_slot, lim);
					fill_count--;
					if (fill_count == '0)
						tail_slot = head_slot;
					ok = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (fill_count != '0) begin
					tail_slot = slot_before(tail_slot, lim);
					fill_count--;
					if (fill_count == '0)
						head_slot = tail_slot;
					ok = 1'b1;
				end
			end
			CMD_NOP: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		st.accepted    = ok;
		st.front_value = (fill_count != '0) ? slot_mem[head_slot] : EMPTY_VALUE;
		st.rear_value  = (fill_count != '0) ? slot_mem[tail_slot] : EMPTY_VALUE;
		st.is_empty    = (fill_count == '0);
		st.is_full     = (fill_count >= lim);
		return st;
	endfunction

	// Offer one word, record its expected status once it is taken.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
		while (send_gaps_on && $urandom_range(0, 99) < 12) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= cmd;
		req_ch.data_value <= val;
		do @(posedge clk); while (!req_ch.ready);
		awaited_status.push_back(apply_command(cmd, val));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (awaited_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Call only while drained.
	task automatic write_capacity(input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cap_reg    = value[CAP_W-1:0];
		head_slot  = '0;
		tail_slot  = '0;
		fill_count = '0;
	endtask

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return EMPTY_VALUE;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_and_edges();
		send_word(CMD_NOP, 32'h0);
		send_word(CMD_POP_FRONT, 32'h0);
		send_word(CMD_POP_BACK, 32'hFFFF_FFFF);
		for (int c = CMD_NOP + 1; c <= CMD_LAST; c++)
			send_word(c[CMD_W-1:0], $urandom);
		send_word(CMD_PUSH_FRONT, 32'h8000_0000);
		send_word(CMD_PUSH_BACK, 32'h7FFF_FFFF);
		send_word(CMD_PUSH_FRONT, EMPTY_VALUE);
		send_word(CMD_PUSH_BACK, 32'h0);
		// unknown commands leave a non-empty deque untouched too
		send_word(CMD_LAST[CMD_W-1:0], 32'h1234_5678);
		send_word(CMD_POP_FRONT, 32'h0);
		send_word(CMD_POP_BACK, 32'h0);
		send_word(CMD_POP_FRONT, 32'h0);
		send_word(CMD_POP_BACK, 32'h0);
		send_word(CMD_POP_BACK, 32'h0);
		send_word(CMD_NOP, 32'h0);
		drain();
	endtask

	task automatic test_capacity_floor();
		// zero acts as one
		write_capacity(32'd0);
		send_word(CMD_PUSH_BACK, 32'hA5A5_5A5A);
		send_word(CMD_PUSH_FRONT, 32'h5A5A_A5A5);
		send_word(CMD_POP_BACK, 32'h0);
		send_word(CMD_POP_FRONT, 32'h0);
		send_word(CMD_PUSH_FRONT, 32'h0000_0001);
		drain();
		// a write empties a deque that still holds a word
		write_capacity(32'd1);
		send_word(CMD_NOP, 32'h0);
		send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFE);
		send_word(CMD_PUSH_BACK, 32'h0);
		send_word(CMD_POP_FRONT, 32'h0);
		drain();
	endtask

	task automatic test_fill_to_max();
		// above DEPTH saturates
		write_capacity(32'd2047);
		for (int i = 0; i < CDQ_DEPTH; i++)
			send_word(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_data());
		send_word(CMD_PUSH_FRONT, $urandom);
		send_word(CMD_PUSH_BACK, $urandom);
		send_word(CMD_NOP, 32'h0);
		for (int i = 0; i < 40; i++)
			send_word($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom);
		drain();
	endtask

	task automatic test_random_mix();
		logic [APB_DW-1:0] caps [] = '{32'd3, 32'd2, 32'd5, 32'd8, 32'd16, 32'd7, 32'd64,
			32'd1, 32'd1000, 32'd4, 32'hFFFF_F806, 32'd1024, 32'd1025};
		int push_pct;
		int roll;
		logic [CMD_W-1:0] cmd;
		foreach (caps[k]) begin
			write_capacity(caps[k]);
			// one phase runs with no idling on either side
			send_gaps_on   = (k != 3);
			recv_stalls_on = (k != 3);
			for (int i = 0; i < 32; i++) begin
				// swing between filling and emptying
				push_pct = ((i / 14) % 2) ? 20 : 80;
				roll = $urandom_range(0, 99);
				if (roll < 3)
					cmd = CMD_W'($urandom_range(CMD_NOP + 1, CMD_LAST));
				else if (roll < 8)
					cmd = CMD_NOP;
				else if ($urandom_range(0, 99) < push_pct)
					cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				else
					cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				send_word(cmd, pick_data());
				// hold off until every result is in
				if (k == 6 && i == 28)
					drain();
			end
			drain();
		end
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
	endtask

	always @(posedge clk) begin
		deque_status_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_status.size() == 0) begin
					$error("result word with no expectation pending");
					error_count++;
				end else begin
					want = awaited_status.pop_front();
					if (rsp_ch.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, rsp_ch.accepted);
						error_count++;
					end
					if (rsp_ch.front_value !== want.front_value) begin
						$error("front_value: expected %0d, got %0d",
							$signed(want.front_value), rsp_ch.front_value);
						error_count++;
					end
					if (rsp_ch.rear_value !== want.rear_value) begin
						$error("rear_value: expected %0d, got %0d",
							$signed(want.rear_value), rsp_ch.rear_value);
						error_count++;
					end
					if (rsp_ch.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
						error_count++;
					end
					if (rsp_ch.is_full !== want.is_full) begin
						$error("is_full: expected %0d, got %0d", want.is_full, rsp_ch.is_full);
						error_count++;
					end
				end
			end
			rsp_ch.ready <= !recv_stalls_on || ($urandom_range(0, 99) >= 12);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		error_count    = 0;
		cycle_count    = 0;
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		cap_reg        = CAP_RESET;
		head_slot      = '0;
		tail_slot      = '0;
		fill_count     = '0;
		foreach (slot_mem[i])
			slot_mem[i] = '0;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.command    = CMD_NOP;
		req_ch.data_value = '0;
		rsp_ch.ready      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_edges();
		test_capacity_floor();
		test_fill_to_max();
		test_random_mix();

		drain();
		if (error_count == 0 && awaited_status.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
